FILE: rtl/cts_pkg.sv
package cts_pkg;

  localparam int CTS_LINE_BITS   = 16;
  localparam int CTS_COLUMN_BITS = 12;

  // char, end flag, class, warning
  localparam int CTS_FIXED_BITS  = 14;

  localparam int CTS_MAX_RES     = 3;
  localparam int CTS_QDEPTH      = 4;
  localparam int CTS_QPTR_BITS   = $clog2(CTS_QDEPTH);
  localparam int CTS_QCNT_BITS   = $clog2(CTS_QDEPTH + 1);
  localparam int CTS_PUSH_BITS   = $clog2(CTS_MAX_RES + 1);

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  localparam logic [2:0] CLS_STRING  = 3'd0;
  localparam logic [2:0] CLS_INTEGER = 3'd1;
  localparam logic [2:0] CLS_IDENT   = 3'd2;
  localparam logic [2:0] CLS_SYMBOL  = 3'd3;
  localparam logic [2:0] CLS_UNKNOWN = 3'd4;

  localparam logic [1:0] WARN_NONE     = 2'd0;
  localparam logic [1:0] WARN_MISMATCH = 2'd1;
  localparam logic [1:0] WARN_UNTERM   = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_QUOTE,
    MODE_SLASH,
    MODE_COMMENT
  } cts_mode_t;

  typedef struct packed {
    logic [2:0] cls;
    logic [1:0] warn;
  } cts_tag_t;

  localparam cts_tag_t TAG_NONE   = '{cls: CLS_STRING, warn: WARN_NONE};
  localparam cts_tag_t TAG_SYMBOL = '{cls: CLS_SYMBOL, warn: WARN_NONE};

  function automatic logic cts_is_space(logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic cts_is_quote(logic [7:0] b);
    return (b == CH_DQUOTE) || (b == CH_SQUOTE);
  endfunction

  function automatic logic cts_is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic cts_is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic cts_is_sym(logic [7:0] b);
    logic p;
    p = ((b >= 8'h21) && (b <= 8'h2F)) || ((b >= 8'h3A) && (b <= 8'h40)) ||
        ((b >= 8'h5B) && (b <= 8'h60)) || ((b >= 8'h7B) && (b <= 8'h7E));
    return p && !cts_is_quote(b);
  endfunction

  // class and warning from the first and last characters of a token
  function automatic cts_tag_t cts_classify(logic [7:0] f, logic [7:0] l);
    cts_tag_t t;
    t.cls  = CLS_UNKNOWN;
    t.warn = WARN_NONE;
    if (cts_is_sym(f)) begin
      t.cls = CLS_SYMBOL;
    end else if (cts_is_quote(f) && (f == l)) begin
      t.cls = CLS_STRING;
    end else if (cts_is_quote(f)) begin
      t.warn = cts_is_quote(l) ? WARN_MISMATCH : WARN_UNTERM;
    end else if (cts_is_digit(f)) begin
      t.cls = CLS_INTEGER;
    end else if (cts_is_alpha(f)) begin
      t.cls = CLS_IDENT;
    end
    return t;
  endfunction

endpackage

FILE: rtl/cts_in_if.sv
interface cts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_text;

  modport source (output valid, source_byte, end_of_text, input ready);
  modport sink   (input valid, source_byte, end_of_text, output ready);
endinterface

FILE: rtl/cts_out_if.sv
interface cts_out_if #(
  parameter int LINE_BITS   = cts_pkg::CTS_LINE_BITS,
  parameter int COLUMN_BITS = cts_pkg::CTS_COLUMN_BITS
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             token_char;
  logic                   token_end;
  logic [2:0]             token_class;
  logic [1:0]             quote_warning;
  logic [LINE_BITS-1:0]   start_line;
  logic [COLUMN_BITS-1:0] start_column;

  modport source (output valid, token_char, token_end, token_class, quote_warning,
                  start_line, start_column, input ready);
  modport sink   (input valid, token_char, token_end, token_class, quote_warning,
                  start_line, start_column, output ready);
endinterface

FILE: rtl/cts_queue.sv
module cts_queue #(
  parameter int W = 42
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cts_pkg::CTS_PUSH_BITS-1:0] push_cnt,
  input  logic [W-1:0]                      push_data [cts_pkg::CTS_MAX_RES],
  output logic                              room,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [W-1:0]                      out_data
);
  import cts_pkg::*;

  logic [W-1:0]             mem_r [CTS_QDEPTH];
  logic [CTS_QPTR_BITS-1:0] wr_ptr_r;
  logic [CTS_QPTR_BITS-1:0] rd_ptr_r;
  logic [CTS_QCNT_BITS-1:0] cnt_r;
  logic                     pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = (cnt_r <= CTS_QCNT_BITS'(CTS_QDEPTH - CTS_MAX_RES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + CTS_QPTR_BITS'(push_cnt);
      rd_ptr_r <= rd_ptr_r + CTS_QPTR_BITS'(pop);
      cnt_r    <= cnt_r + CTS_QCNT_BITS'(push_cnt) - CTS_QCNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CTS_MAX_RES; i++) begin
      if (i < push_cnt) begin
        mem_r[wr_ptr_r + CTS_QPTR_BITS'(i)] <= push_data[i];
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CTS_QCNT_BITS'(CTS_QDEPTH))
    else $error("result queue over depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != '0) |-> room)
    else $error("push without room");

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[CTS_QPTR_BITS-1:0])
    else $error("queue pointers disagree with count");

endmodule

FILE: rtl/cts_scan.sv
module cts_scan #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 12,
  parameter int RW          = 42
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        source_byte,
  input  logic                              end_of_text,
  input  logic                              room,
  output logic [cts_pkg::CTS_PUSH_BITS-1:0] push_cnt,
  output logic [RW-1:0]                     push_data [cts_pkg::CTS_MAX_RES]
);
  import cts_pkg::*;

  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

  cts_mode_t              mode_r,        mode_nxt;
  logic [7:0]             held_char_r,   held_char_nxt;
  logic                   held_valid_r,  held_valid_nxt;
  logic [7:0]             first_char_r,  first_char_nxt;
  logic [LINE_BITS-1:0]   line_r,        line_nxt;
  logic [COLUMN_BITS-1:0] col_r,         col_nxt;
  logic [LINE_BITS-1:0]   tok_line_r,    tok_line_nxt;
  logic [COLUMN_BITS-1:0] tok_col_r,     tok_col_nxt;
  logic [LINE_BITS-1:0]   slash_line_r,  slash_line_nxt;
  logic [COLUMN_BITS-1:0] slash_col_r,   slash_col_nxt;

  logic                     acc;
  logic                     plain;
  logic [CTS_PUSH_BITS-1:0] n;
  logic [RW-1:0]            em [CTS_MAX_RES];
  logic [7:0]               b;

  function automatic logic [RW-1:0] pack_res(logic [7:0] ch, logic last, cts_tag_t tag,
                                             logic [LINE_BITS-1:0] ln,
                                             logic [COLUMN_BITS-1:0] col);
    return {ch, last, tag, ln, col};
  endfunction

  assign in_ready = room;
  assign acc      = in_valid && room;
  assign b        = source_byte;
  assign push_cnt = n;
  assign push_data = em;

  always_comb begin
    mode_nxt       = mode_r;
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    first_char_nxt = first_char_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    tok_line_nxt   = tok_line_r;
    tok_col_nxt    = tok_col_r;
    slash_line_nxt = slash_line_r;
    slash_col_nxt  = slash_col_r;
    plain          = 1'b0;
    n              = '0;
    for (int i = 0; i < CTS_MAX_RES; i++) begin
      em[i] = '0;
    end

    if (acc) begin
      // mode-specific handling
      unique case (mode_r)
        MODE_QUOTE: begin
          if (b == CH_NL) begin
            if (held_valid_nxt) begin
              em[n] = pack_res(held_char_nxt, 1'b1,
                               cts_classify(first_char_nxt, held_char_nxt),
                               tok_line_nxt, tok_col_nxt);
              n = n + 1'b1;
            end
            held_valid_nxt = 1'b0;
            mode_nxt       = MODE_IDLE;
          end else begin
            if (held_valid_nxt) begin
              em[n] = pack_res(held_char_nxt, 1'b0, TAG_NONE, tok_line_nxt, tok_col_nxt);
              n = n + 1'b1;
            end else begin
              first_char_nxt = b;
              tok_line_nxt   = line_r;
              tok_col_nxt    = col_r;
            end
            held_char_nxt  = b;
            held_valid_nxt = 1'b1;
            if (cts_is_quote(b)) begin
              mode_nxt = MODE_WORD;
            end
          end
        end
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            mode_nxt = MODE_COMMENT;
          end else begin
            // pending slash was a lone symbol
            em[n] = pack_res(CH_SLASH, 1'b1, TAG_SYMBOL, slash_line_r, slash_col_r);
            n = n + 1'b1;
            mode_nxt = MODE_IDLE;
            plain    = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (b == CH_NL) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_WORD: begin
          plain = 1'b1;
        end
        default: begin
          held_valid_nxt = 1'b0;
          plain          = 1'b1;
        end
      endcase

      // ordinary byte outside quotes and comments
      if (plain) begin
        priority if (cts_is_space(b) || (b == CH_SLASH) || cts_is_sym(b)) begin
          if (held_valid_nxt) begin
            em[n] = pack_res(held_char_nxt, 1'b1,
                             cts_classify(first_char_nxt, held_char_nxt),
                             tok_line_nxt, tok_col_nxt);
            n = n + 1'b1;
          end
          held_valid_nxt = 1'b0;
          if (b == CH_SLASH) begin
            slash_line_nxt = line_r;
            slash_col_nxt  = col_r;
            mode_nxt       = MODE_SLASH;
          end else begin
            mode_nxt = MODE_IDLE;
            if (!cts_is_space(b)) begin
              em[n] = pack_res(b, 1'b1, TAG_SYMBOL, line_r, col_r);
              n = n + 1'b1;
            end
          end
        end else begin
          if (held_valid_nxt) begin
            em[n] = pack_res(held_char_nxt, 1'b0, TAG_NONE, tok_line_nxt, tok_col_nxt);
            n = n + 1'b1;
          end else begin
            first_char_nxt = b;
            tok_line_nxt   = line_r;
            tok_col_nxt    = col_r;
          end
          held_char_nxt  = b;
          held_valid_nxt = 1'b1;
          mode_nxt       = cts_is_quote(b) ? MODE_QUOTE : MODE_WORD;
        end
      end

      // saturating position counters
      if (b == CH_NL) begin
        line_nxt = (&line_r) ? line_r : line_r + LINE_ONE;
        col_nxt  = COL_ONE;
      end else begin
        col_nxt  = (&col_r) ? col_r : col_r + COL_ONE;
      end

      // flush at end of text
      if (end_of_text) begin
        if (mode_nxt == MODE_SLASH) begin
          em[n] = pack_res(CH_SLASH, 1'b1, TAG_SYMBOL, slash_line_nxt, slash_col_nxt);
          n = n + 1'b1;
        end
        if (held_valid_nxt) begin
          em[n] = pack_res(held_char_nxt, 1'b1,
                           cts_classify(first_char_nxt, held_char_nxt),
                           tok_line_nxt, tok_col_nxt);
          n = n + 1'b1;
        end
        mode_nxt       = MODE_IDLE;
        held_char_nxt  = '0;
        held_valid_nxt = 1'b0;
        first_char_nxt = '0;
        line_nxt       = LINE_ONE;
        col_nxt        = COL_ONE;
        tok_line_nxt   = LINE_ONE;
        tok_col_nxt    = COL_ONE;
        slash_line_nxt = LINE_ONE;
        slash_col_nxt  = COL_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
      first_char_r <= '0;
      line_r       <= LINE_ONE;
      col_r        <= COL_ONE;
      tok_line_r   <= LINE_ONE;
      tok_col_r    <= COL_ONE;
      slash_line_r <= LINE_ONE;
      slash_col_r  <= COL_ONE;
    end else begin
      mode_r       <= mode_nxt;
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      first_char_r <= first_char_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      tok_line_r   <= tok_line_nxt;
      tok_col_r    <= tok_col_nxt;
      slash_line_r <= slash_line_nxt;
      slash_col_r  <= slash_col_nxt;
    end
  end

  a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> (mode_r == MODE_WORD || mode_r == MODE_QUOTE))
    else $error("held char outside a word or quote");

  a_quote_held: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_QUOTE) |-> held_valid_r)
    else $error("quote mode without held char");

  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && end_of_text) |=> (mode_r == MODE_IDLE && !held_valid_r &&
                              line_r == LINE_ONE && col_r == COL_ONE))
    else $error("state not cleared after end of text");

endmodule

FILE: rtl/c_like_token_scanner.sv
// Byte-stream tokenizer for C-like text. One source byte is accepted per cycle
// whenever the 4-entry result queue has room for three results, one more than one byte
// can cause (at most one result already waiting). Each token character comes out
// one byte late so that the last one can carry token_end, the token class, the
// quote warning and the start line/column; a symbol comes out with no delay, while
// a lone slash is only known once the next byte (or end_of_text) arrives. Results
// leave the queue at one per cycle, so the port runs at one
// item per cycle as long as the output side keeps up; a run of bytes that each
// produce two results is paced by the output port. After the item that
// carries end_of_text, all pending output is flushed and the scanner and position
// counters return to their reset state, ready for the next text on the next cycle.
module c_like_token_scanner #(
  parameter int LINE_BITS   = cts_pkg::CTS_LINE_BITS,
  parameter int COLUMN_BITS = cts_pkg::CTS_COLUMN_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  cts_in_if.sink        in_chan,
  cts_out_if.source     out_chan
);
  import cts_pkg::*;

  // packed result: char, end, class, warning, line, column
  localparam int RW       = CTS_FIXED_BITS + LINE_BITS + COLUMN_BITS;
  localparam int OFS_LINE = COLUMN_BITS;
  localparam int OFS_WARN = COLUMN_BITS + LINE_BITS;
  localparam int OFS_CLS  = OFS_WARN + 2;
  localparam int OFS_END  = OFS_CLS + 3;
  localparam int OFS_CHAR = OFS_END + 1;

  logic                     room;
  logic [CTS_PUSH_BITS-1:0] push_cnt;
  logic [RW-1:0]            push_data [CTS_MAX_RES];
  logic [RW-1:0]            out_data;

  // per-byte scanner: mode, held char and position counters
  cts_scan #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .RW          (RW)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .source_byte (in_chan.source_byte),
    .end_of_text (in_chan.end_of_text),
    .room        (room),
    .push_cnt    (push_cnt),
    .push_data   (push_data)
  );

  // result queue, also the output register
  cts_queue #(
    .W (RW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .room      (room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  // unpack the queue head onto the result fields
  assign out_chan.token_char    = out_data[OFS_CHAR +: 8];
  assign out_chan.token_end     = out_data[OFS_END];
  assign out_chan.token_class   = out_data[OFS_CLS +: 3];
  assign out_chan.quote_warning = out_data[OFS_WARN +: 2];
  assign out_chan.start_line    = out_data[OFS_LINE +: LINE_BITS];
  assign out_chan.start_column  = out_data[0 +: COLUMN_BITS];

endmodule

FILE: bench/c_like_token_scanner_checker.sv
module c_like_token_scanner_checker
  import cts_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 in_source_byte,
  input  logic                       in_end_of_text,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [7:0]                 out_token_char,
  input  logic                       out_token_end,
  input  logic [2:0]                 out_token_class,
  input  logic [1:0]                 out_quote_warning,
  input  logic [CTS_LINE_BITS-1:0]   out_start_line,
  input  logic [CTS_COLUMN_BITS-1:0] out_start_column,
  output int                         n_errors,
  output int                         n_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CTS_LINE_BITS-1:0]   LINE_TOP = '1;
  localparam logic [CTS_COLUMN_BITS-1:0] COL_TOP  = '1;

  typedef struct packed {
    logic [7:0]                 ch;
    logic                       is_end;
    logic [2:0]                 cls;
    logic [1:0]                 warn;
    logic [CTS_LINE_BITS-1:0]   line;
    logic [CTS_COLUMN_BITS-1:0] col;
  } token_char_t;

  token_char_t token_q[$];

  cts_mode_t                  mode;
  logic [7:0]                 held_ch;
  logic [7:0]                 lead_ch;
  logic                       held_ok;
  logic [CTS_LINE_BITS-1:0]   line_no;
  logic [CTS_COLUMN_BITS-1:0] col_no;
  logic [CTS_LINE_BITS-1:0]   tok_line;
  logic [CTS_COLUMN_BITS-1:0] tok_col;
  logic [CTS_LINE_BITS-1:0]   slash_line;
  logic [CTS_COLUMN_BITS-1:0] slash_col;
  int                         err_total = 0;

  function automatic logic is_blank(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_quote_ch(logic [7:0] b);
    return b == CH_DQUOTE || b == CH_SQUOTE;
  endfunction

  function automatic logic is_num(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  // printable punctuation, quotes excluded
  function automatic logic is_sym_char(logic [7:0] b);
    return b inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]} &&
           !is_quote_ch(b);
  endfunction

  task automatic report(input string msg);
    err_total++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic clear_state();
    mode       = MODE_IDLE;
    held_ch    = '0;
    lead_ch    = '0;
    held_ok    = 1'b0;
    line_no    = CTS_LINE_BITS'(1);
    col_no     = CTS_COLUMN_BITS'(1);
    tok_line   = CTS_LINE_BITS'(1);
    tok_col    = CTS_COLUMN_BITS'(1);
    slash_line = CTS_LINE_BITS'(1);
    slash_col  = CTS_COLUMN_BITS'(1);
  endtask

  task automatic push_held(input logic is_end);
    logic [2:0] cls;
    logic [1:0] warn;
    cls  = CLS_STRING;
    warn = WARN_NONE;
    if (is_end) begin
      if (is_sym_char(lead_ch)) begin
        cls = CLS_SYMBOL;
      end else if (is_quote_ch(lead_ch) && lead_ch == held_ch) begin
        cls = CLS_STRING;
      end else begin
        if (is_quote_ch(lead_ch)) warn = is_quote_ch(held_ch) ? WARN_MISMATCH : WARN_UNTERM;
        cls = is_num(lead_ch) ? CLS_INTEGER : is_letter(lead_ch) ? CLS_IDENT : CLS_UNKNOWN;
      end
    end
    token_q.push_back('{held_ch, is_end, cls, warn, tok_line, tok_col});
  endtask

  task automatic keep_char(input logic [7:0] b);
    if (held_ok) begin
      push_held(1'b0);
    end else begin
      lead_ch  = b;
      tok_line = line_no;
      tok_col  = col_no;
    end
    held_ch = b;
    held_ok = 1'b1;
  endtask

  task automatic close_token();
    if (held_ok) push_held(1'b1);
    held_ok = 1'b0;
  endtask

  task automatic take_plain(input logic [7:0] b);
    if (is_blank(b)) begin
      close_token();
      mode = MODE_IDLE;
    end else if (b == CH_SLASH) begin
      close_token();
      slash_line = line_no;
      slash_col  = col_no;
      mode       = MODE_SLASH;
    end else if (is_quote_ch(b)) begin
      keep_char(b);
      mode = MODE_QUOTE;
    end else if (is_sym_char(b)) begin
      close_token();
      token_q.push_back('{b, 1'b1, CLS_SYMBOL, WARN_NONE, line_no, col_no});
      mode = MODE_IDLE;
    end else begin
      keep_char(b);
      mode = MODE_WORD;
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eot);
    case (mode)
      MODE_QUOTE: begin
        if (b == CH_NL) begin
          close_token();
          mode = MODE_IDLE;
        end else begin
          keep_char(b);
          if (is_quote_ch(b)) mode = MODE_WORD;
        end
      end
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode = MODE_COMMENT;
        end else begin
          token_q.push_back('{CH_SLASH, 1'b1, CLS_SYMBOL, WARN_NONE, slash_line, slash_col});
          mode = MODE_IDLE;
          take_plain(b);
        end
      end
      MODE_COMMENT: begin
        if (b == CH_NL) mode = MODE_IDLE;
      end
      MODE_WORD: begin
        take_plain(b);
      end
      default: begin
        held_ok = 1'b0;
        take_plain(b);
      end
    endcase

    if (b == CH_NL) begin
      if (line_no != LINE_TOP) line_no++;
      col_no = CTS_COLUMN_BITS'(1);
    end else if (col_no != COL_TOP) begin
      col_no++;
    end

    if (eot) begin
      if (mode == MODE_SLASH) begin
        token_q.push_back('{CH_SLASH, 1'b1, CLS_SYMBOL, WARN_NONE, slash_line, slash_col});
      end
      close_token();
      clear_state();
    end
  endtask

  task automatic check_result();
    token_char_t got;
    token_char_t want;
    string       bad;
    got = '{out_token_char, out_token_end, out_token_class, out_quote_warning,
            out_start_line, out_start_column};
    if (token_q.size() == 0) begin
      report($sformatf("unexpected token char %h end %b", got.ch, got.is_end));
    end else begin
      want = token_q.pop_front();
      bad  = "";
      if (got.ch !== want.ch) bad = {bad, " token_char"};
      if (got.is_end !== want.is_end) bad = {bad, " token_end"};
      if (got.cls !== want.cls) bad = {bad, " token_class"};
      if (got.warn !== want.warn) bad = {bad, " quote_warning"};
      if (got.line !== want.line) bad = {bad, " start_line"};
      if (got.col !== want.col) bad = {bad, " start_column"};
      if (bad != "") begin
        report($sformatf("%s: got %h/%b/%0d/%0d/%0d/%0d want %h/%b/%0d/%0d/%0d/%0d", bad,
                         got.ch, got.is_end, got.cls, got.warn, got.line, got.col,
                         want.ch, want.is_end, want.cls, want.warn, want.line, want.col));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      token_q.delete();
    end else begin
      if (in_valid && in_ready) scan_byte(in_source_byte, in_end_of_text);
      if (out_valid && out_ready) check_result();
    end
    n_waiting <= token_q.size();
    n_errors  <= err_total;
  end

endmodule

FILE: bench/c_like_token_scanner_tb.sv
module c_like_token_scanner_tb;
  import cts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT  = 4000;
  // random bytes spread over the three idling phases
  localparam int RANDOM_ITEMS = 190;
  // punctuation that forms one-character symbols (no slash, no quotes)
  localparam string PUNCT = "!#$%&()*+,-.:;<=>?@[\\]^`{|}~";

  logic       clk = 1'b0;
  logic       rst_n;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         n_errors;
  int         n_waiting;
  int         random_sent;
  logic [7:0] text_q[$];

  cts_in_if  in_chan();
  cts_out_if #(.LINE_BITS(CTS_LINE_BITS), .COLUMN_BITS(CTS_COLUMN_BITS)) out_chan();

  c_like_token_scanner u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // watches both channels, predicts every token char and compares
  c_like_token_scanner_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_source_byte    (in_chan.source_byte),
    .in_end_of_text    (in_chan.end_of_text),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_token_char    (out_chan.token_char),
    .out_token_end     (out_chan.token_end),
    .out_token_class   (out_chan.token_class),
    .out_quote_warning (out_chan.quote_warning),
    .out_start_line    (out_chan.start_line),
    .out_start_column  (out_chan.start_column),
    .n_errors          (n_errors),
    .n_waiting         (n_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // text building
  // ---------------------------------------------------------------------------

  task automatic add_str(input string s);
    foreach (s[i]) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25)) : 8'(8'h41 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  // space, tab, newline, vertical tab, form feed or carriage return
  function automatic logic [7:0] rand_blank();
    return $urandom_range(2) == 0 ? 8'h20 : 8'(8'h09 + $urandom_range(4));
  endfunction

  function automatic logic [7:0] rand_quote();
    return $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
  endfunction

  // printable string body char, never a quote
  function automatic logic [7:0] rand_body();
    logic [7:0] b;
    b = 8'($urandom_range(8'h20, 8'h7E));
    return (b == CH_DQUOTE || b == CH_SQUOTE) ? 8'h5F : b;
  endfunction

  // one lexical piece with random content; mostly well formed, some noise
  task automatic add_piece();
    int         n;
    int         pick;
    logic [7:0] q;
    pick = $urandom_range(11);
    case (pick)
      0, 1: begin
        // identifier, digits allowed after the first letter
        text_q.push_back(rand_letter());
        n = $urandom_range(5);
        repeat (n) text_q.push_back($urandom_range(2) ? rand_letter() : rand_digit());
      end
      2: begin
        n = $urandom_range(1, 4);
        repeat (n) text_q.push_back(rand_digit());
      end
      3, 4: begin
        // string: mostly closed by the same quote, sometimes the other one,
        // a newline, or nothing at all
        q = rand_quote();
        text_q.push_back(q);
        n = $urandom_range(4);
        repeat (n) text_q.push_back(rand_body());
        case ($urandom_range(9))
          7:       text_q.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
          8:       text_q.push_back(CH_NL);
          9:       ;
          default: text_q.push_back(q);
        endcase
        // sometimes a token goes on after the closing quote
        if ($urandom_range(3) == 0) text_q.push_back(rand_letter());
      end
      5: text_q.push_back(PUNCT[$urandom_range(PUNCT.len() - 1)]);
      6: text_q.push_back(CH_SLASH);
      7: begin
        // line comment, sometimes cut off by the end of text
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_SLASH);
        n = $urandom_range(6);
        repeat (n) begin
          q = 8'($urandom_range(255));
          text_q.push_back(q == CH_NL ? 8'h41 : q);
        end
        if ($urandom_range(4) != 0) text_q.push_back(CH_NL);
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) text_q.push_back(rand_blank());
      end
      9:  text_q.push_back(8'($urandom_range(255)));
      10: text_q.push_back($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hFF))
                                              : 8'($urandom_range(8'h00, 8'h08)));
      default: text_q.push_back(rand_quote());
    endcase
    if ($urandom_range(1)) text_q.push_back(rand_blank());
  endtask

  // ---------------------------------------------------------------------------
  // sending
  // ---------------------------------------------------------------------------

  // one item; valid only drops inside a sender gap, so it is never lowered
  // and raised in the same step
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.source_byte <= b;
    in_chan.end_of_text <= eot;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // the whole text, end_of_text on its final byte
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // sender holds off until every predicted token char has come out
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
  endtask

  task automatic random_texts(input int target);
    int pieces;
    while (random_sent < target) begin
      pieces = $urandom_range(1, 10);
      repeat (pieces) add_piece();
      random_sent += text_q.size();
      send_text();
      if ($urandom_range(3) == 0) drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.source_byte  <= 8'h00;
    in_chan.end_of_text  <= 1'b0;
    send_idle_pct        = 15;
    recv_idle_pct        = 73;
    random_sent          = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a lone quote is a string
    add_str("'");
    send_text();
    // mismatched quotes
    add_str("\"ab'");
    send_text();
    // string cut by a newline, then a word, then a slash flushed at the end
    add_str("\"a\nb/");
    send_text();
    // integer, identifier, comment dropped at the end of text
    add_str("9 x//c");
    send_text();
    // byte extremes and high bytes act as word chars, tab moves the column,
    // a quote held at the end of text
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h09);
    text_q.push_back(8'h80);
    text_q.push_back(8'h01);
    text_q.push_back(CH_SQUOTE);
    send_text();
    drain();

    // phase 1: light sender gaps, heavy receiver stalls
    random_texts(RANDOM_ITEMS / 3);
    drain();

    // phase 2: roles swapped
    send_idle_pct = 73;
    recv_idle_pct = 15;
    random_texts(2 * RANDOM_ITEMS / 3);
    drain();

    // phase 3: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_texts(RANDOM_ITEMS);
    drain();

    // tail for anything the block still emits
    repeat (16) @(posedge clk);
    if (n_errors == 0) begin
      $display("c_like_token_scanner test passed");
    end else begin
      $display("c_like_token_scanner test failed");
    end
    $finish;
  end

  // watchdog: ends a run that stops moving on both channels
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("c_like_token_scanner test failed");
    $finish;
  end

endmodule
